/* rtl/core/ptfr_pkg.sv */
// shared types and constants for the paged translation core
// no dependencies
package ptfr_pkg;

	localparam int OFF_W = 24;
	localparam int LPAGE_W = 12;
	localparam int STAMP_W = 32;
	localparam int KEY_W = 8;

	localparam logic [1:0] FUNC_READ = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_LOAD = 2'd2;

	localparam logic [2:0] ST_HIT = 3'd0;
	localparam logic [2:0] ST_FAULT = 3'd1;
	localparam logic [2:0] ST_RANGE = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_LOADED = 3'd4;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_P_RD = 11'b000_0000_0010,
		S_P_CK = 11'b000_0000_0100,
		S_CALC = 11'b000_0000_1000,
		S_F_RD = 11'b000_0001_0000,
		S_F_CK = 11'b000_0010_0000,
		S_V_RD = 11'b000_0100_0000,
		S_V_CK = 11'b000_1000_0000,
		S_VSEL = 11'b001_0000_0000,
		S_UPD  = 11'b010_0000_0000,
		S_DONE = 11'b100_0000_0000
	} state_t;

endpackage

/* rtl/core/ptfr_ram.sv */
// generic single write port ram with registered read
// no dependencies
module ptfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/paged_translation_fifo_replace_core.sv */
// paged address translation with fifo page replacement, top level
// uses ptfr_pkg and ptfr_ram for the process table and frame table
// a load entry goes straight to the output; an access scans the process table slot by slot, then the
// frames in use, and on a full-table fault all frames again, through the one read port of each table ram
// one item at a time; next item taken once the result sits in the output register
// reset clears in-use, used and dirty flags, the load counter and the control state
module paged_translation_fifo_replace_core
	import ptfr_pkg::*;
#(
	parameter int PAGE_BITS = 12,
	parameter int FRAME_COUNT = 16,
	parameter int PROC_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  proc_key,
	input  logic [31:0] virt_addr,
	input  logic [2:0]  entry_slot,
	input  logic [11:0] entry_first_page,
	input  logic [23:0] entry_size,
	input  logic        entry_valid,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] phys_addr,
	output logic [11:0] swap_in_page,
	output logic [3:0]  victim_frame,
	output logic        writeback,
	output logic [11:0] evicted_page
);
	localparam int SW = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
	localparam int PW = $clog2(PROC_SLOTS + 1);
	localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int CW = $clog2(FRAME_COUNT + 1);
	localparam int PE_W = KEY_W + LPAGE_W + OFF_W;
	localparam int FE_W = LPAGE_W + STAMP_W;
	localparam logic [OFF_W-1:0] POFF_MASK = OFF_W'((1 << PAGE_BITS) - 1);

	state_t state_q;
	logic [PROC_SLOTS-1:0] proc_in_use_q;
	logic [FRAME_COUNT-1:0] frame_used_q;
	logic [FRAME_COUNT-1:0] frame_dirty_q;
	logic [STAMP_W-1:0] load_counter_q;

	logic [1:0] func_q;
	logic [KEY_W-1:0] key_q;
	logic [OFF_W-1:0] off_q;
	logic [PW-1:0] pidx_q;
	logic [CW-1:0] fidx_q;
	logic [LPAGE_W-1:0] base_q;
	logic [OFF_W-1:0] size_q;
	logic [OFF_W-1:0] count_q;
	logic [LPAGE_W-1:0] page_q;
	logic [2:0] res_status_q;
	logic [FW-1:0] frame_q;
	logic wb_q;
	logic [LPAGE_W-1:0] evict_q;

	logic own_found_q;
	logic [FW-1:0] own_best_q;
	logic [STAMP_W-1:0] own_age_q;
	logic [LPAGE_W-1:0] own_page_q;
	logic [FW-1:0] all_best_q;
	logic [STAMP_W-1:0] all_age_q;
	logic [LPAGE_W-1:0] all_page_q;

	logic out_valid_q;
	logic [2:0] ostatus_q;
	logic [15:0] ophys_q;
	logic [11:0] oswap_q;
	logic [3:0] ovictim_q;
	logic owb_q;
	logic [11:0] oevict_q;

	logic in_acc;
	logic [31:0] slot32;
	logic p_we;
	logic [SW-1:0] p_waddr;
	logic [PE_W-1:0] p_rdata;
	logic f_we;
	logic [FE_W-1:0] f_rdata;
	logic [KEY_W-1:0] rd_key;
	logic [LPAGE_W-1:0] rd_base;
	logic [OFF_W-1:0] rd_size;
	logic [LPAGE_W-1:0] rd_fpage;
	logic [STAMP_W-1:0] rd_stamp;
	logic [STAMP_W-1:0] age;
	logic [LPAGE_W-1:0] rel;
	logic [OFF_W-1:0] off_pages;
	logic [31:0] phys32;
	logic [31:0] vict32;
	logic out_free;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign slot32 = 32'(entry_slot);
	assign p_we = in_acc && (func == FUNC_LOAD) && (slot32 < 32'(PROC_SLOTS));
	assign p_waddr = slot32[SW-1:0];
	assign f_we = (state_q == S_UPD);

	assign {rd_key, rd_base, rd_size} = p_rdata;
	assign {rd_fpage, rd_stamp} = f_rdata;
	assign age = load_counter_q - rd_stamp;
	assign rel = rd_fpage - base_q;
	assign off_pages = off_q >> PAGE_BITS;
	assign phys32 = (32'(frame_q) << PAGE_BITS) + 32'(off_q & POFF_MASK);
	assign vict32 = 32'(frame_q);
	assign out_free = !out_valid_q || !out_stall;

	ptfr_ram #(.WIDTH(PE_W), .DEPTH(PROC_SLOTS)) u_proc_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata ({proc_key, entry_first_page, entry_size}),
		.raddr (pidx_q[SW-1:0]),
		.rdata (p_rdata)
	);

	ptfr_ram #(.WIDTH(FE_W), .DEPTH(FRAME_COUNT)) u_frame_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (frame_q),
		.wdata ({page_q, load_counter_q}),
		.raddr (fidx_q[FW-1:0]),
		.rdata (f_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			proc_in_use_q <= '0;
			frame_used_q <= '0;
			frame_dirty_q <= '0;
			load_counter_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (func == FUNC_LOAD) begin
							if (p_we) begin
								proc_in_use_q[p_waddr] <= entry_valid;
							end
							state_q <= S_DONE;
						end else begin
							state_q <= S_P_RD;
						end
					end
				end
				S_P_RD: begin
					if (pidx_q == PW'(PROC_SLOTS)) begin
						state_q <= S_DONE;
					end else if (proc_in_use_q[pidx_q[SW-1:0]]) begin
						state_q <= S_P_CK;
					end
				end
				S_P_CK: begin
					if (rd_key == key_q) begin
						state_q <= S_CALC;
					end else begin
						state_q <= S_P_RD;
					end
				end
				S_CALC: begin
					if (off_q >= size_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_F_RD;
					end
				end
				S_F_RD: begin
					if (fidx_q == CW'(FRAME_COUNT)) begin
						state_q <= S_V_RD;
					end else if (!frame_used_q[fidx_q[FW-1:0]]) begin
						state_q <= S_UPD;
					end else begin
						state_q <= S_F_CK;
					end
				end
				S_F_CK: begin
					if (rd_fpage == page_q) begin
						if (func_q == FUNC_WRITE) begin
							frame_dirty_q[fidx_q[FW-1:0]] <= 1'b1;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_F_RD;
					end
				end
				S_V_RD: begin
					state_q <= S_V_CK;
				end
				S_V_CK: begin
					if (fidx_q == CW'(FRAME_COUNT - 1)) begin
						state_q <= S_VSEL;
					end else begin
						state_q <= S_V_RD;
					end
				end
				S_VSEL: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					frame_used_q[frame_q] <= 1'b1;
					frame_dirty_q[frame_q] <= (func_q == FUNC_WRITE);
					load_counter_q <= load_counter_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= func;
				key_q <= proc_key;
				off_q <= virt_addr[OFF_W-1:0];
				pidx_q <= '0;
				fidx_q <= '0;
				wb_q <= 1'b0;
				evict_q <= '0;
				frame_q <= '0;
				res_status_q <= (func == FUNC_LOAD) ? ST_LOADED : ST_UNKNOWN;
			end
			S_P_RD: begin
				if (pidx_q != PW'(PROC_SLOTS) && !proc_in_use_q[pidx_q[SW-1:0]]) begin
					pidx_q <= pidx_q + 1'b1;
				end
			end
			S_P_CK: begin
				if (rd_key == key_q) begin
					base_q <= rd_base;
					size_q <= rd_size;
				end else begin
					pidx_q <= pidx_q + 1'b1;
				end
			end
			S_CALC: begin
				page_q <= base_q + off_pages[LPAGE_W-1:0];
				count_q <= (size_q >> PAGE_BITS) + OFF_W'(|(size_q & POFF_MASK));
				res_status_q <= (off_q >= size_q) ? ST_RANGE : ST_FAULT;
				own_found_q <= 1'b0;
			end
			S_F_RD: begin
				if (fidx_q == CW'(FRAME_COUNT)) begin
					fidx_q <= '0;
				end else if (!frame_used_q[fidx_q[FW-1:0]]) begin
					frame_q <= fidx_q[FW-1:0];
				end
			end
			S_F_CK: begin
				if (rd_fpage == page_q) begin
					frame_q <= fidx_q[FW-1:0];
					res_status_q <= ST_HIT;
				end else begin
					fidx_q <= fidx_q + 1'b1;
				end
			end
			S_V_CK: begin
				if (fidx_q == '0 || age > all_age_q) begin
					all_best_q <= fidx_q[FW-1:0];
					all_age_q <= age;
					all_page_q <= rd_fpage;
				end
				if ((OFF_W'(rel) < count_q) && (!own_found_q || age > own_age_q)) begin
					own_found_q <= 1'b1;
					own_best_q <= fidx_q[FW-1:0];
					own_age_q <= age;
					own_page_q <= rd_fpage;
				end
				if (fidx_q != CW'(FRAME_COUNT - 1)) begin
					fidx_q <= fidx_q + 1'b1;
				end
			end
			S_VSEL: begin
				frame_q <= own_found_q ? own_best_q : all_best_q;
				wb_q <= frame_dirty_q[own_found_q ? own_best_q : all_best_q];
				evict_q <= own_found_q ? own_page_q : all_page_q;
			end
			S_DONE: begin
				if (out_free) begin
					ostatus_q <= res_status_q;
					ophys_q <= '0;
					oswap_q <= '0;
					ovictim_q <= '0;
					owb_q <= 1'b0;
					oevict_q <= '0;
					if (res_status_q == ST_HIT || res_status_q == ST_FAULT) begin
						ophys_q <= phys32[15:0];
					end
					if (res_status_q == ST_FAULT) begin
						oswap_q <= page_q;
						ovictim_q <= vict32[3:0];
						owb_q <= wb_q;
						oevict_q <= wb_q ? evict_q : '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status = ostatus_q;
	assign phys_addr = ophys_q;
	assign swap_in_page = oswap_q;
	assign victim_frame = ovictim_q;
	assign writeback = owb_q;
	assign evicted_page = oevict_q;
endmodule

/* sim/tb_paged_translation_fifo_replace_core.sv */
// testbench for paged_translation_fifo_replace_core: random and directed items against a
// built-in translation predictor, results checked in order field by field
// depends on ptfr_pkg and the core rtl
module tb_paged_translation_fifo_replace_core;
	import ptfr_pkg::*;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  proc_key;
		logic [31:0] virt_addr;
		logic [2:0]  entry_slot;
		logic [11:0] entry_first_page;
		logic [23:0] entry_size;
		logic        entry_valid;
	} access_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] phys_addr;
		logic [11:0] swap_in_page;
		logic [3:0]  victim_frame;
		logic        writeback;
		logic [11:0] evicted_page;
	} xlate_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [7:0]  proc_key;
	logic [31:0] virt_addr;
	logic [2:0]  entry_slot;
	logic [11:0] entry_first_page;
	logic [23:0] entry_size;
	logic        entry_valid;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [15:0] phys_addr;
	logic [11:0] swap_in_page;
	logic [3:0]  victim_frame;
	logic        writeback;
	logic [11:0] evicted_page;

	paged_translation_fifo_replace_core u_dut (.*);

	// predictor state
	logic        pt_use [8];
	logic [7:0]  pt_key [8];
	logic [11:0] pt_base [8];
	logic [23:0] pt_size [8];
	logic        fr_used [16];
	logic [11:0] fr_page [16];
	logic        fr_dirty [16];
	logic [31:0] fr_stamp [16];
	logic [31:0] load_cnt;

	access_t pending_items[$];
	xlate_t  expected_xlate[$];
	int      errors = 0;
	int      n_checked = 0;
	int      n_faults = 0;
	int      n_wb = 0;
	bit      quiet = 0;
	bit      stim_done = 0;
	int      in_gap = 0;
	int      out_gap = 0;

	function automatic xlate_t translate(access_t a);
		xlate_t r;
		int slot;
		int fr;
		int vic;
		int own_best;
		int all_best;
		logic [31:0] own_age;
		logic [31:0] all_age;
		logic [31:0] age;
		logic [23:0] off;
		logic [11:0] pg;
		logic [11:0] rel;
		logic [24:0] cnt;
		bit hit;
		bit own_found;
		r = '0;
		if (a.func == FUNC_LOAD) begin
			pt_use[a.entry_slot] = a.entry_valid;
			pt_key[a.entry_slot] = a.proc_key;
			pt_base[a.entry_slot] = a.entry_first_page;
			pt_size[a.entry_slot] = a.entry_size;
			r.status = ST_LOADED;
			return r;
		end
		slot = -1;
		for (int s = 0; s < 8; s++)
			if (slot < 0 && pt_use[s] && pt_key[s] == a.proc_key)
				slot = s;
		if (slot < 0) begin
			r.status = ST_UNKNOWN;
			return r;
		end
		off = a.virt_addr[23:0];
		if (off >= pt_size[slot]) begin
			r.status = ST_RANGE;
			return r;
		end
		pg = pt_base[slot] + 12'(off >> 12);
		hit = 0;
		fr = 0;
		for (int f = 0; f < 16; f++) begin
			if (!fr_used[f])
				break;
			if (fr_page[f] == pg) begin
				fr = f;
				hit = 1;
				break;
			end
		end
		if (hit) begin
			r.status = ST_HIT;
		end else begin
			vic = -1;
			for (int f = 0; f < 16; f++)
				if (vic < 0 && !fr_used[f])
					vic = f;
			if (vic < 0) begin
				cnt = (pt_size[slot] >> 12) + ((pt_size[slot][11:0] != 0) ? 1 : 0);
				own_found = 0;
				own_best = 0;
				all_best = 0;
				own_age = 0;
				all_age = 0;
				for (int f = 0; f < 16; f++) begin
					age = load_cnt - fr_stamp[f];
					rel = fr_page[f] - pt_base[slot];
					if (f == 0 || age > all_age) begin
						all_best = f;
						all_age = age;
					end
					if (rel < cnt && (!own_found || age > own_age)) begin
						own_found = 1;
						own_best = f;
						own_age = age;
					end
				end
				vic = own_found ? own_best : all_best;
			end
			fr = vic;
			if (fr_used[fr] && fr_dirty[fr]) begin
				r.writeback = 1;
				r.evicted_page = fr_page[fr];
			end
			fr_used[fr] = 1;
			fr_page[fr] = pg;
			fr_dirty[fr] = 0;
			fr_stamp[fr] = load_cnt;
			load_cnt = load_cnt + 1;
			r.status = ST_FAULT;
			r.swap_in_page = pg;
			r.victim_frame = 4'(fr);
		end
		if (a.func == FUNC_WRITE)
			fr_dirty[fr] = 1;
		r.phys_addr = 16'((fr << 12) + off[11:0]);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_checked);
		errors++;
	endtask

	function automatic access_t load_item(int sl, logic [7:0] k, logic [11:0] fp,
			logic [23:0] sz, logic v);
		access_t a;
		a = '0;
		a.func = FUNC_LOAD;
		a.entry_slot = 3'(sl);
		a.proc_key = k;
		a.entry_first_page = fp;
		a.entry_size = sz;
		a.entry_valid = v;
		a.virt_addr = $urandom;
		return a;
	endfunction

	function automatic access_t acc_item(logic [1:0] f, logic [7:0] k, logic [31:0] va);
		access_t a;
		a.func = f;
		a.proc_key = k;
		a.virt_addr = va;
		a.entry_slot = 3'($urandom);
		a.entry_first_page = 12'($urandom);
		a.entry_size = 24'($urandom);
		a.entry_valid = 1'($urandom);
		return a;
	endfunction

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		access_t a;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				void'(pending_items.pop_front());
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 9) == 0) begin
					in_gap = $urandom_range(0, 14);
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					a = pending_items[0];
					in_valid <= 1'b1;
					func <= a.func;
					proc_key <= a.proc_key;
					virt_addr <= a.virt_addr;
					entry_slot <= a.entry_slot;
					entry_first_page <= a.entry_first_page;
					entry_size <= a.entry_size;
					entry_valid <= a.entry_valid;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// predict on acceptance
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			expected_xlate.push_back(translate({func, proc_key, virt_addr, entry_slot,
				entry_first_page, entry_size, entry_valid}));
	end

	// monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		xlate_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_xlate.size() == 0) begin
					report_mismatch("unexpected result", status, 0);
				end else begin
					e = expected_xlate.pop_front();
					if (status !== e.status) report_mismatch("status", status, e.status);
					if (phys_addr !== e.phys_addr)
						report_mismatch("phys_addr", phys_addr, e.phys_addr);
					if (swap_in_page !== e.swap_in_page)
						report_mismatch("swap_in_page", swap_in_page, e.swap_in_page);
					if (victim_frame !== e.victim_frame)
						report_mismatch("victim_frame", victim_frame, e.victim_frame);
					if (writeback !== e.writeback)
						report_mismatch("writeback", writeback, e.writeback);
					if (evicted_page !== e.evicted_page)
						report_mismatch("evicted_page", evicted_page, e.evicted_page);
					if (e.status == ST_FAULT) n_faults++;
					if (e.writeback) n_wb++;
				end
				n_checked++;
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_gap = $urandom_range(0, 14);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [7:0] keys [4];
		int k;
		int pick;
		pt_use = '{default: 0};
		pt_key = '{default: 0};
		pt_base = '{default: 0};
		pt_size = '{default: 0};
		fr_used = '{default: 0};
		fr_page = '{default: 0};
		fr_dirty = '{default: 0};
		fr_stamp = '{default: 0};
		load_cnt = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		func = FUNC_READ;
		proc_key = '0;
		virt_addr = '0;
		entry_slot = '0;
		entry_first_page = '0;
		entry_size = '0;
		entry_valid = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: unknown process, loads, bounds, page wrap, duplicate key, func 3
		pending_items.push_back(acc_item(FUNC_READ, 8'hff, 32'hffff_ffff));
		pending_items.push_back(load_item(0, 8'h41, 12'hfff, 24'h003001, 1));
		pending_items.push_back(load_item(1, 8'h41, 12'h000, 24'hffffff, 1));
		pending_items.push_back(load_item(7, 8'hff, 12'h000, 24'hffffff, 1));
		pending_items.push_back(load_item(6, 8'h00, 12'h800, 24'h000000, 1));
		pending_items.push_back(acc_item(FUNC_READ, 8'h41, 32'hff00_0000));
		pending_items.push_back(acc_item(FUNC_WRITE, 8'h41, 32'h0000_3000));
		pending_items.push_back(acc_item(FUNC_READ, 8'h41, 32'h0000_3001));
		pending_items.push_back(acc_item(FUNC_WRITE, 8'h41, 32'h0000_1fff));
		pending_items.push_back(acc_item(2'd3, 8'h41, 32'h0000_2abc));
		pending_items.push_back(acc_item(FUNC_READ, 8'h00, 32'h0));
		pending_items.push_back(acc_item(FUNC_WRITE, 8'hff, 32'h00ff_fffe));
		pending_items.push_back(acc_item(FUNC_READ, 8'hff, 32'h00ff_ffff));
		pending_items.push_back(load_item(0, 8'h41, 12'h000, 24'h000000, 0));
		pending_items.push_back(acc_item(FUNC_READ, 8'h41, 32'h0000_5555));
		pending_items.push_back(load_item(1, 8'h41, 12'h000, 24'h000000, 0));
		pending_items.push_back(load_item(7, 8'hff, 12'h000, 24'h000000, 0));

		// random: a few processes, mostly in-range accesses so the frame table churns
		for (int i = 0; i < 4; i++) begin
			keys[i] = 8'($urandom);
			pending_items.push_back(load_item(i, keys[i], 12'($urandom),
				24'($urandom_range(1, 12) * 4096 - $urandom_range(0, 4095)), 1));
		end
		for (int i = 0; i < 1000; i++) begin
			pick = $urandom_range(0, 99);
			k = $urandom_range(0, 3);
			if (pick < 4) begin
				keys[k] = 8'($urandom);
				pending_items.push_back(load_item(k + $urandom_range(0, 1) * 4, keys[k],
					12'($urandom), (pick == 0) ? 24'($urandom) :
					24'($urandom_range(1, 12) * 4096 - $urandom_range(0, 4095)),
					pick != 1));
			end else if (pick < 8) begin
				pending_items.push_back(acc_item(2'($urandom), 8'($urandom), $urandom));
			end else begin
				pending_items.push_back(acc_item(2'($urandom_range(0, 1)), keys[k],
					{8'($urandom), 24'($urandom_range(0, 12 * 4096))}));
			end
			if (i == 850) begin
				while (pending_items.size() > 0) @(posedge clk);
				quiet = 1;
			end
		end
		while (pending_items.size() > 0 || expected_xlate.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("checked %0d results: %0d page faults, %0d writebacks", n_checked,
			n_faults, n_wb);
		if (errors == 0 && expected_xlate.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout");
		$display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/ptfr_pkg.sv
rtl/core/ptfr_ram.sv
rtl/core/paged_translation_fifo_replace_core.sv
sim/tb_paged_translation_fifo_replace_core.sv
